// ----- rtl/core/register_machine_execute_defines.svh -----
// Assertion macros for the register machine execute block.
// Included by modules that carry concurrent checks.
`ifndef REGISTER_MACHINE_EXECUTE_DEFINES_SVH
`define REGISTER_MACHINE_EXECUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define RME_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define RME_ASSERT(label, clk, rst_n, prop, msg)
`endif
`ifndef SYNTHESIS
`define RME_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RME_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/rme_pkg.sv -----
// Types and constants shared by the register machine execute block.
// No dependencies.
`timescale 1ns / 1ps
package rme_pkg;
    typedef struct packed {
        logic [7:0]  cmd;
        logic [23:0] operand;
    } rme_in_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        print_valid;
        logic [63:0] print_value;
        logic [63:0] result_r0;
        logic        halted;
        logic [2:0]  error_code;
    } rme_out_t;

    localparam logic [7:0] OP_LDI   = 8'h00;
    localparam logic [7:0] OP_MOV   = 8'h01;
    localparam logic [7:0] OP_ADD   = 8'h02;
    localparam logic [7:0] OP_SUB   = 8'h03;
    localparam logic [7:0] OP_MUL   = 8'h04;
    localparam logic [7:0] OP_DIV   = 8'h05;
    localparam logic [7:0] OP_JMP   = 8'h06;
    localparam logic [7:0] OP_JZ    = 8'h07;
    localparam logic [7:0] OP_JNZ   = 8'h08;
    localparam logic [7:0] OP_INC   = 8'h09;
    localparam logic [7:0] OP_DEC   = 8'h0A;
    localparam logic [7:0] OP_CALL  = 8'h0B;
    localparam logic [7:0] OP_RET   = 8'h0C;
    localparam logic [7:0] OP_JE    = 8'h0D;
    localparam logic [7:0] OP_JNE   = 8'h0E;
    localparam logic [7:0] OP_PRINT = 8'h0F;
    localparam logic [7:0] OP_MOVR0 = 8'h10;
    localparam logic [7:0] OP_DONE  = 8'h11;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_DIV0    = 3'd1;
    localparam logic [2:0] ERR_ILLEGAL = 3'd2;
    localparam logic [2:0] ERR_OVER    = 3'd3;
    localparam logic [2:0] ERR_UNDER   = 3'd4;
    localparam logic [2:0] ERR_PCRANGE = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } rme_state_t;

    // divider handshake
    typedef struct packed {
        logic start;
    } rme_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rme_div_sts_t;

    function automatic logic [15:0] jump_target(input logic [15:0] t);
        jump_target = (t - 16'd1) << 2;
    endfunction
endpackage

// ----- rtl/core/register_machine_execute.sv -----
// Register machine execute stage: runs one 32-bit instruction per input
// transaction on sixteen 64-bit registers held in a synchronous memory.
// Channels: in_valid/in_stall/in_data carry cmd and operand; out_valid/
// out_stall/out_data carry next PC, print value, R0, halt and error code.
// An instruction passes through read, execute and R0 refresh before its
// result; a multiply adds the ST_MUL state (three 32x32 partial products),
// a divide the ST_DIV state with the one-bit-per-cycle divider.
// A new instruction is taken as soon as the previous result has been
// handed to the output register, so instructions do not overlap; the
// register file read-modify-write and R0 readback lie between them.
// Reset clears all registers (a clearing pass after reset, during which no
// input is taken), the PC, the stack level and the halt state.
// The call stack memories are not cleared; only written entries are read.
// When the receiver stalls, the result is held in the output register; the
// next instruction runs up to its output step and waits there, and the
// input stalls until the output register frees up.
// After a halt, every instruction is consumed and answered with the
// current state, print flag clear.
`timescale 1ns / 1ps
`include "register_machine_execute_defines.svh"
module register_machine_execute #(
    parameter int STACK_DEPTH = 16,
    parameter int MEM_BYTES   = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rme_pkg::rme_in_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rme_pkg::rme_out_t  out_data
);
    import rme_pkg::*;

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);

    rme_state_t  state_reg, state_next;
    logic [4:0]  clr_reg;
    logic        clearing;
    logic [7:0]  cmd_reg;
    logic [23:0] opd_reg;
    logic [15:0] pc_reg;
    logic [LW-1:0] lvl_reg;
    logic        halt_reg;
    logic [2:0]  err_reg;
    logic        phase_reg;
    logic        out_valid_reg;
    logic        out_load;
    rme_out_t    out_reg;

    logic [15:0] ret_mem [STACK_DEPTH];
    logic [15:0] r15_mem [STACK_DEPTH];
    logic [15:0] ret_rd_reg;
    logic [15:0] r15_rd_reg;

    logic [3:0]  ra, rb, rc, rh;
    logic [15:0] imm;
    logic [3:0]  rd_a, rd_b;
    logic [63:0] va, vb;
    logic        we;
    logic [3:0]  waddr;
    logic [63:0] wdata;
    logic [SW-1:0] top_idx;
    logic [SW-1:0] push_idx;

    logic [63:0] pp_ll_reg, pp_lh_reg, pp_hl_reg;
    logic [63:0] mul_res;
    rme_div_ctl_t div_ctl;
    rme_div_sts_t div_sts;
    logic [63:0] quotient;

    assign ra  = opd_reg[19:16];
    assign rb  = opd_reg[11:8];
    assign rc  = opd_reg[3:0];
    assign rh  = opd_reg[23:20];
    assign imm = opd_reg[15:0];
    assign clearing = !clr_reg[4];
    assign top_idx  = SW'(lvl_reg - LW'(1));
    assign push_idx = SW'(lvl_reg);
    // load the output register once the previous result has left it
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    rme_regfile u_rf (
        .clk     (clk),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (va),
        .rdata_b (vb),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata)
    );

    rme_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (va),
        .divisor  (vb),
        .sts      (div_sts),
        .quotient (quotient)
    );

    assign mul_res = pp_ll_reg + ((pp_lh_reg + pp_hl_reg) << 32);

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= 64'(va[31:0]) * 64'(vb[31:0]);
        pp_lh_reg <= 64'(va[31:0]) * 64'(vb[63:32]);
        pp_hl_reg <= 64'(va[63:32]) * 64'(vb[31:0]);
    end

    // stack memories: written on call, top entry read every cycle for the read state
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ && !halt_reg && cmd_reg == OP_CALL
            && 32'(lvl_reg) < STACK_DEPTH)
        begin
            ret_mem[push_idx] <= pc_reg + 16'd4;
            r15_mem[push_idx] <= va[15:0];
        end
        ret_rd_reg <= ret_mem[top_idx];
        r15_rd_reg <= r15_mem[top_idx];
    end

    // read address selection
    always_comb
    begin
        rd_a = ra;
        rd_b = rb;
        if (state_reg == ST_IDLE)
        begin
            rd_a = in_data.operand[19:16];
            rd_b = in_data.operand[11:8];
            unique case (in_data.cmd)
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    rd_a = in_data.operand[11:8];
                    rd_b = in_data.operand[3:0];
                end
                OP_CALL:
                begin
                    rd_a = 4'd15;
                end
                OP_JE, OP_JNE:
                begin
                    rd_a = in_data.operand[23:20];
                    rd_b = in_data.operand[19:16];
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_WRITE || state_reg == ST_OUT)
        begin
            rd_a = 4'd0;
        end
        else
        begin
            // hold operands while multiply or divide is running
            rd_a = rb;
            rd_b = rc;
        end
    end

    logic [15:0] pc_next;
    logic [LW-1:0] lvl_next;
    logic        halt_next;
    logic [2:0]  err_next;
    logic        pv_next;
    logic [63:0] pval_next;
    logic        pv_reg;
    logic [63:0] pval_reg;
    logic [15:0] pc4;

    assign pc4 = pc_reg + 16'd4;

    // next state and write-back: clearing writes, execute in ST_READ, MUL/DIV results
    always_comb
    begin
        state_next = state_reg;
        we        = 1'b0;
        waddr     = ra;
        wdata     = va;
        pc_next   = pc_reg;
        lvl_next  = lvl_reg;
        halt_next = halt_reg;
        err_next  = err_reg;
        pv_next   = pv_reg;
        pval_next = pval_reg;
        div_ctl.start = 1'b0;
        if (clearing)
        begin
            we    = 1'b1;
            waddr = clr_reg[3:0];
            wdata = '0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !clearing)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
                pv_next    = 1'b0;
                pval_next  = '0;
                if (!halt_reg)
                begin
                    pc_next = pc4;
                    case (cmd_reg)
                        OP_LDI:
                        begin
                            we = 1'b1;
                            wdata = 64'(imm);
                        end
                        OP_MOV:
                        begin
                            we = 1'b1;
                            wdata = vb;
                        end
                        OP_ADD:
                        begin
                            we = 1'b1;
                            wdata = va + vb;
                        end
                        OP_SUB:
                        begin
                            we = 1'b1;
                            wdata = va - vb;
                        end
                        OP_MUL:
                        begin
                            state_next = ST_MUL;
                        end
                        OP_DIV:
                        begin
                            if (vb == '0)
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_DIV0;
                            end
                            else
                            begin
                                div_ctl.start = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        OP_JMP: pc_next = jump_target(imm);
                        OP_JZ:
                        begin
                            if (va == '0) pc_next = jump_target(imm);
                        end
                        OP_JNZ:
                        begin
                            if (va != '0) pc_next = jump_target(imm);
                        end
                        OP_INC:
                        begin
                            we = 1'b1;
                            wdata = va + 64'(imm);
                        end
                        OP_DEC:
                        begin
                            we = 1'b1;
                            wdata = va - 64'(imm);
                        end
                        OP_CALL:
                        begin
                            if (32'(lvl_reg) >= STACK_DEPTH)
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_OVER;
                            end
                            else
                            begin
                                lvl_next = lvl_reg + LW'(1);
                                pc_next  = jump_target(imm);
                            end
                        end
                        OP_RET:
                        begin
                            if (lvl_reg == '0)
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_UNDER;
                            end
                            else
                            begin
                                lvl_next = lvl_reg - LW'(1);
                                we       = 1'b1;
                                waddr    = 4'd15;
                                wdata    = 64'(r15_rd_reg);
                                pc_next  = ret_rd_reg;
                            end
                        end
                        OP_JE:
                        begin
                            if (va == vb) pc_next = jump_target(imm);
                        end
                        OP_JNE:
                        begin
                            if (va != vb) pc_next = jump_target(imm);
                        end
                        OP_PRINT:
                        begin
                            pv_next   = 1'b1;
                            pval_next = va;
                        end
                        OP_MOVR0:
                        begin
                            we    = 1'b1;
                            waddr = 4'd0;
                            wdata = va;
                        end
                        OP_DONE:
                        begin
                            halt_next = 1'b1;
                            err_next  = ERR_NONE;
                        end
                        default:
                        begin
                            halt_next = 1'b1;
                            err_next  = ERR_ILLEGAL;
                        end
                    endcase
                    if (!halt_next && 32'(pc_next) + 32'd1 >= MEM_BYTES)
                    begin
                        halt_next = 1'b1;
                        err_next  = ERR_PCRANGE;
                    end
                end
            end
            ST_MUL:
            begin
                // first phase: partial products; second phase: sum and write
                if (phase_reg)
                begin
                    we = 1'b1;
                    wdata = mul_res;
                    state_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    we = 1'b1;
                    wdata = quotient;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_reg       <= '0;
            pc_reg        <= '0;
            lvl_reg       <= '0;
            halt_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 5'd1;
            end
            pc_reg    <= pc_next;
            lvl_reg   <= lvl_next;
            halt_reg  <= halt_next;
            err_reg   <= err_next;
            phase_reg <= (state_reg == ST_MUL) ? !phase_reg : 1'b0;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !clearing)
        begin
            cmd_reg <= in_data.cmd;
            opd_reg <= in_data.operand;
        end
        pv_reg   <= pv_next;
        pval_reg <= pval_next;
    end

    always_comb
    begin
        out_reg.next_pc     = pc_reg;
        out_reg.print_valid = pv_reg;
        out_reg.print_value = pval_reg;
        // R0 read issued in ST_WRITE returns here in ST_OUT
        out_reg.result_r0   = va;
        out_reg.halted      = halt_reg;
        out_reg.error_code  = err_reg;
    end

    rme_out_t out_hold_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hold_reg <= out_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE) || clearing;
    assign out_valid = out_valid_reg;
    assign out_data  = out_hold_reg;

    `RME_ASSERT(a_out_valid_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "stalled result dropped")
    `RME_ASSERT(a_halt_sticky, clk, rst_n, halt_reg |=> halt_reg, "halt flag dropped")
    `RME_ASSERT(a_lvl_bound, clk, rst_n, 32'(lvl_reg) <= STACK_DEPTH, "stack level beyond depth")
    `RME_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> $stable(out_data), "stalled result changed")
endmodule

// ----- rtl/core/rme_regfile.sv -----
// Register file memory: two synchronous read ports, one write port.
// No dependencies; standalone memory.
`timescale 1ns / 1ps
module rme_regfile (
    input  logic        clk,
    input  logic [3:0]  raddr_a,
    input  logic [3:0]  raddr_b,
    output logic [63:0] rdata_a,
    output logic [63:0] rdata_b,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [63:0] wdata
);
    logic [63:0] mem_reg [16];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end
endmodule

// ----- rtl/core/rme_divider.sv -----
// Radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
// Depends on rme_pkg for the control structs.
`timescale 1ns / 1ps
module rme_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rme_pkg::rme_div_ctl_t ctl,
    input  logic [63:0]          dividend,
    input  logic [63:0]          divisor,
    output rme_pkg::rme_div_sts_t sts,
    output logic [63:0]          quotient
);
    import rme_pkg::*;

    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- verif/rme_checker.sv -----
// Scoreboard for the register machine execute block: tracks accepted
// instructions, predicts each result and compares it field by field.
// Depends on rme_pkg for the channel payload types and opcode constants.
`timescale 1ns / 1ps
module rme_checker
    import rme_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int MEM_BYTES   = 16384
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  rme_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_stall,
    input  rme_out_t out_data,
    output int       errors,
    output int       pending
);
    logic [63:0] regs [16];
    logic [15:0] pc;
    logic [15:0] ret_pcs [STACK_DEPTH];
    logic [15:0] saved_r15 [STACK_DEPTH];
    int          depth;
    logic        halt;
    logic [2:0]  err;
    rme_out_t    expected_q[$];

    function automatic logic [15:0] branch_dest(logic [15:0] t);
        return 16'((t - 16'd1) * 16'd4);
    endfunction

    function automatic void stop(logic [2:0] code);
        halt = 1'b1;
        err  = code;
    endfunction

    function automatic rme_out_t execute_instr(rme_in_t ins);
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [3:0]  rc;
        logic [3:0]  rh;
        logic [15:0] imm;
        rme_out_t    res;
        ra  = ins.operand[19:16];
        rb  = ins.operand[11:8];
        rc  = ins.operand[3:0];
        rh  = ins.operand[23:20];
        imm = ins.operand[15:0];
        res = '0;
        if (!halt)
        begin
            pc = pc + 16'd4;
            case (ins.cmd)
                OP_LDI:   regs[ra] = {48'd0, imm};
                OP_MOV:   regs[ra] = regs[rb];
                OP_ADD:   regs[ra] = regs[rb] + regs[rc];
                OP_SUB:   regs[ra] = regs[rb] - regs[rc];
                OP_MUL:   regs[ra] = regs[rb] * regs[rc];
                OP_DIV:
                begin
                    if (regs[rc] == 64'd0)
                        stop(ERR_DIV0);
                    else
                        regs[ra] = regs[rb] / regs[rc];
                end
                OP_JMP:   pc = branch_dest(imm);
                OP_JZ:    if (regs[ra] == 64'd0) pc = branch_dest(imm);
                OP_JNZ:   if (regs[ra] != 64'd0) pc = branch_dest(imm);
                OP_INC:   regs[ra] = regs[ra] + {48'd0, imm};
                OP_DEC:   regs[ra] = regs[ra] - {48'd0, imm};
                OP_CALL:
                begin
                    if (depth >= STACK_DEPTH)
                        stop(ERR_OVER);
                    else
                    begin
                        saved_r15[depth] = regs[15][15:0];
                        ret_pcs[depth]   = pc;
                        depth++;
                        pc = branch_dest(imm);
                    end
                end
                OP_RET:
                begin
                    if (depth == 0)
                        stop(ERR_UNDER);
                    else
                    begin
                        depth--;
                        regs[15] = {48'd0, saved_r15[depth]};
                        pc       = ret_pcs[depth];
                    end
                end
                OP_JE:    if (regs[rh] == regs[ra]) pc = branch_dest(imm);
                OP_JNE:   if (regs[rh] != regs[ra]) pc = branch_dest(imm);
                OP_PRINT:
                begin
                    res.print_valid = 1'b1;
                    res.print_value = regs[ra];
                end
                OP_MOVR0: regs[0] = regs[ra];
                OP_DONE:  stop(ERR_NONE);
                default:  stop(ERR_ILLEGAL);
            endcase
            if (!halt && int'(pc) + 1 >= MEM_BYTES)
                stop(ERR_PCRANGE);
        end
        res.next_pc    = pc;
        res.result_r0  = regs[0];
        res.halted     = halt;
        res.error_code = err;
        return res;
    endfunction

    function automatic int field_bad(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rme_out_t exp_r;
        int       bad;
        if (!rst_n)
        begin
            foreach (regs[i]) regs[i] = '0;
            pc      = '0;
            depth   = 0;
            halt    = 1'b0;
            err     = ERR_NONE;
            errors  = 0;
            pending = 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q = {expected_q, execute_instr(in_data)};
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction: expected none, actual %h",
                             $time, out_data);
                    errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    bad = field_bad("next_pc", exp_r.next_pc, out_data.next_pc)
                        + field_bad("print_valid", exp_r.print_valid, out_data.print_valid)
                        + field_bad("print_value", exp_r.print_value, out_data.print_value)
                        + field_bad("result_r0", exp_r.result_r0, out_data.result_r0)
                        + field_bad("halted", exp_r.halted, out_data.halted)
                        + field_bad("error_code", exp_r.error_code, out_data.error_code);
                    if (bad != 0)
                        errors++;
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

// ----- verif/tb_register_machine_execute.sv -----
// Top of the register machine execute testbench: clock, reset, instruction
// stream and output stall pattern; rme_checker does the prediction.
// Depends on rme_pkg, register_machine_execute and rme_checker.
`timescale 1ns / 1ps
module tb_register_machine_execute;
    import rme_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    rme_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    rme_out_t out_data;
    int       errors;
    int       pending;
    int       call_depth;
    int       burst_left;
    int       since_jump;

    register_machine_execute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    rme_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one instruction and hold it until taken; gaps fall between bursts.
    task automatic send_instr(logic [7:0] c, logic [23:0] o);
        int gap;
        in_data  <= '{cmd: c, operand: o};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_jump(logic [7:0] c, logic [7:0] hi, logic [15:0] t);
        send_instr(c, {hi, t});
        since_jump = 0;
    endtask

    // Random well-formed instruction; keeps the PC in range and the stack legal.
    // Only an unconditional jump restarts the straight-line count; a return
    // forces one right after it.
    task automatic random_instr();
        logic [23:0] o;
        logic [3:0]  r;
        int          pick;
        o    = 24'($urandom);
        pick = $urandom_range(0, 19);
        if (since_jump > 40)
            pick = 19;
        since_jump++;
        case (pick)
            0, 1:   send_instr(OP_LDI, o);
            2:      send_instr(OP_MOV, o);
            3, 4:   send_instr(OP_ADD, o);
            5:      send_instr(OP_SUB, o);
            6, 7:   send_instr(OP_MUL, o);
            8:
            begin
                r = o[3:0];
                send_instr(OP_LDI, {4'($urandom), r, 16'($urandom_range(1, 65535))});
                send_instr(OP_DIV, o);
            end
            9:      send_instr(OP_INC, o);
            10:     send_instr(OP_DEC, o);
            11:     send_instr(OP_PRINT, o);
            12:     send_instr(OP_MOVR0, o);
            13:     send_instr(OP_JZ, {o[23:16], 16'($urandom_range(1, 4000))});
            14:     send_instr(OP_JNZ, {o[23:16], 16'($urandom_range(1, 4000))});
            15:     send_instr(OP_JE, {o[23:16], 16'($urandom_range(1, 4000))});
            16:     send_instr(OP_JNE, {o[23:16], 16'($urandom_range(1, 4000))});
            17:
            begin
                if (call_depth < 16)
                begin
                    send_instr(OP_CALL, {o[23:16], 16'($urandom_range(1, 4000))});
                    call_depth++;
                end
                else
                    send_instr(OP_PRINT, o);
            end
            18:
            begin
                if (call_depth > 0)
                begin
                    send_instr(OP_RET, o);
                    call_depth--;
                    since_jump = 41;
                end
                else
                    send_instr(OP_INC, o);
            end
            default: send_jump(OP_JMP, o[23:16], 16'($urandom_range(1, 4000)));
        endcase
    endtask

    // The machine halts for good, so one halting cause ends each run.
    task automatic halt_machine();
        case ($urandom_range(0, 5))
            0:
            begin
                send_instr(OP_LDI, 24'h070000);
                send_instr(OP_DIV, 24'h030207);
            end
            1:      send_instr(8'($urandom_range(8'h12, 8'hFF)), 24'($urandom));
            2:
            begin
                while (call_depth <= 16)
                begin
                    send_jump(OP_CALL, 8'h00, 16'($urandom_range(1, 4000)));
                    call_depth++;
                end
            end
            3:
            begin
                while (call_depth >= 0)
                begin
                    send_instr(OP_RET, 24'($urandom));
                    call_depth--;
                end
            end
            4:      send_jump(OP_JMP, 8'hFF, ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd4097);
            default: send_instr(OP_DONE, 24'($urandom));
        endcase
    endtask

    // Receiver: segments of free flow, random stall and dense stall, one long hold.
    initial
    begin
        int mode;
        int seg;
        int cyc;
        int hold;
        out_stall <= 1'b0;
        mode = 0;
        seg  = 0;
        cyc  = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 3000)
                hold = 400;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg == 0)
                begin
                    mode = $urandom_range(0, 2);
                    seg  = $urandom_range(20, 300);
                end
                seg--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 1) == 1);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // End the run when no transaction moves for too long.
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("tb_register_machine_execute: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        call_depth = 0;
        burst_left = 0;
        since_jump = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: wraparound, JE/JNE both ways, JZ/JNZ taken, call/ret with R15
        send_instr(OP_LDI, 24'hF1FFFF);
        send_instr(OP_DEC, 24'h020001);
        send_instr(OP_ADD, 24'h030201);
        send_instr(OP_SUB, 24'h040102);
        send_instr(OP_MUL, 24'h050202);
        send_instr(OP_MUL, 24'h060201);
        send_instr(OP_LDI, 24'h070003);
        send_instr(OP_DIV, 24'h080207);
        send_instr(OP_MOV, 24'hF9F2F0);
        send_instr(OP_INC, 24'h0AFFFF);
        send_jump(OP_JZ, 8'h00, 16'd10);
        send_jump(OP_JNZ, 8'h02, 16'd20);
        send_jump(OP_JE, 8'h92, 16'd30);
        send_jump(OP_JNE, 8'h92, 16'd40);
        send_jump(OP_JE, 8'h12, 16'd50);
        send_jump(OP_JNE, 8'h12, 16'd4000);
        send_instr(OP_MOV, 24'h0F0200);
        send_jump(OP_CALL, 8'h00, 16'd100);
        send_instr(OP_INC, 24'h0F0005);
        send_instr(OP_RET, 24'hFFFFFF);
        send_instr(OP_PRINT, 24'h020000);
        send_instr(OP_MOVR0, 24'h050000);
        send_jump(OP_JMP, 8'h00, 16'd1);
        send_instr(OP_PRINT, 24'h000000);

        for (int i = 0; i < 2000; i++)
        begin
            random_instr();
            if (i == 1000)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
        halt_machine();
        for (int i = 0; i < 40; i++)
            send_instr(8'($urandom), 24'($urandom));

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_register_machine_execute: clean");
        else
            $display("tb_register_machine_execute: errors");
        $finish;
    end
endmodule

// ----- register_machine_execute.f -----
+incdir+rtl/core
rtl/core/rme_pkg.sv
rtl/core/rme_regfile.sv
rtl/core/rme_divider.sv
rtl/core/register_machine_execute.sv
verif/rme_checker.sv
verif/tb_register_machine_execute.sv
